// ===== rtl/core/cmmp_pkg.sv =====
// Shared types and constants for the crop, mirror and mean-subtract block.
package cmmp_pkg;

  // Field widths fixed by the interface
  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 18;
  localparam int VAL_W   = 10;
  localparam int SHIFT_W = 6;
  localparam int NCHAN   = 3;
  localparam int REG_W   = 3;
  localparam int DATA_W  = 24;

  // Mode bit positions
  localparam int MODE_MIRROR = 0;
  localparam int MODE_PAD    = 1;
  localparam int MODE_SHIFT  = 2;

  // Register map
  typedef enum logic [REG_W-1:0] {
    REG_OUT_HEIGHT  = 3'd0,
    REG_OUT_WIDTH   = 3'd1,
    REG_ROW_OFFSET  = 3'd2,
    REG_COL_OFFSET  = 3'd3,
    REG_MODE_BITS   = 3'd4,
    REG_MEAN_PIXEL  = 3'd5,
    REG_COLOR_SHIFT = 3'd6
  } reg_idx_t;

  // Configuration register bank
  typedef struct packed {
    logic [DIM_W-1:0]         out_height;
    logic [DIM_W-1:0]         out_width;
    logic [COORD_W-1:0]       row_offset;
    logic [COORD_W-1:0]       col_offset;
    logic [2:0]               mode_bits;
    logic [NCHAN*PIX_W-1:0]   mean_pixel;
    logic [NCHAN*SHIFT_W-1:0] color_shift;
  } cfg_t;

  // One source pixel request
  typedef struct packed {
    logic [COORD_W-1:0]          src_row;
    logic [COORD_W-1:0]          src_col;
    logic [NCHAN-1:0][PIX_W-1:0] chan;
  } pixel_t;

  // The three channel results of one pixel
  typedef struct packed {
    logic [NCHAN-1:0][IDX_W-1:0] idx;
    logic [NCHAN-1:0][VAL_W-1:0] val;
  } result_t;

endpackage

// ===== rtl/core/cmmp_calc.sv =====
// Window test, planar index and mean subtraction for one pixel.
module cmmp_calc
  import cmmp_pkg::*;
#(
  parameter int MAX_DIM    = 256,
  parameter int PAD_PIXELS = 4
) (
  input  cfg_t    cfg,
  input  pixel_t  pix,
  output logic    hit,
  output result_t res
);

  // Sizes above the register range cannot be reached, so clamp to what fits
  localparam int DIM_MAX_REG = (1 << DIM_W) - 1;
  localparam int CLAMP       = (MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM;
  localparam logic [DIM_W-1:0] CLAMP_V = DIM_W'(CLAMP);
  localparam logic [DIM_W-1:0] PAD_V   = DIM_W'(PAD_PIXELS);

  logic [DIM_W-1:0] hs, ws;
  logic [DIM_W-1:0] pr, pc;
  logic [DIM_W-1:0] h, w, col;
  logic [IDX_W-1:0] base, plane;
  logic [VAL_W-1:0] shift_ext;

  // Clamped output size
  assign hs = (32'(cfg.out_height) > CLAMP) ? CLAMP_V : cfg.out_height;
  assign ws = (32'(cfg.out_width) > CLAMP) ? CLAMP_V : cfg.out_width;

  // Padded coordinates and window-relative position
  assign pr = {1'b0, pix.src_row} + (cfg.mode_bits[MODE_PAD] ? PAD_V : '0);
  assign pc = {1'b0, pix.src_col} + (cfg.mode_bits[MODE_PAD] ? PAD_V : '0);
  assign h  = pr - {1'b0, cfg.row_offset};
  assign w  = pc - {1'b0, cfg.col_offset};

  assign hit = (pr >= {1'b0, cfg.row_offset}) && (pc >= {1'b0, cfg.col_offset}) &&
               (h < hs) && (w < ws);

  // Mirrored column when asked
  assign col = cfg.mode_bits[MODE_MIRROR] ? (ws - 9'd1 - w) : w;

  // Row-major offset within a plane and the plane size, modulo the index width
  assign base  = IDX_W'(h) * IDX_W'(ws) + IDX_W'(col);
  assign plane = IDX_W'(hs) * IDX_W'(ws);

  // Per-channel index and value
  always_comb begin
    shift_ext = '0;
    for (int c = 0; c < NCHAN; c++) begin
      res.idx[c] = base + IDX_W'(c) * plane;
      shift_ext  = {{(VAL_W-SHIFT_W){cfg.color_shift[SHIFT_W*c + SHIFT_W-1]}},
                    cfg.color_shift[SHIFT_W*c +: SHIFT_W]};
      res.val[c] = VAL_W'(pix.chan[c]) - VAL_W'(cfg.mean_pixel[PIX_W*c +: PIX_W]) +
                   (cfg.mode_bits[MODE_SHIFT] ? shift_ext : '0);
    end
  end

endmodule

// ===== rtl/core/crop_mirror_mean_planarize_top.sv =====
// Top level: crop window, mirror and mean subtraction with planar output.
//
// Each source pixel request (row, column, three interleaved channel bytes) is
// registered, tested against the crop window and turned into its three planar
// results, then held in a result register. A pixel inside the window leaves as
// three results in turn, channel 0 first, as the result port takes them, so
// the single result port sets the rate at which such pixels pass; a pixel
// outside the window gives no result and leaves the input register without
// waiting on the result register. The first result is offered once the pixel
// has passed the input register and the result register. A new request can be
// taken while earlier results still wait; a hit then stalls in the input register.
// Configuration registers are written one a cycle and are always ready.
module crop_mirror_mean_planarize_top
  import cmmp_pkg::*;
#(
  parameter int MAX_DIM    = 256,
  parameter int PAD_PIXELS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // Pixel requests
  input  logic                     pix_valid,
  output logic                     pix_stall,
  input  logic [COORD_W-1:0]       src_row,
  input  logic [COORD_W-1:0]       src_col,
  input  logic [PIX_W-1:0]         chan0,
  input  logic [PIX_W-1:0]         chan1,
  input  logic [PIX_W-1:0]         chan2,
  // Results
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [IDX_W-1:0]         dest_index,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     last_of_pixel
);

  cfg_t    cfg;
  logic    in_valid;
  pixel_t  in_pix;
  logic    calc_hit;
  result_t calc_res;
  logic    held_valid;
  result_t held_res;
  logic [1:0] sel;
  logic    held_drain, held_ready, in_adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_height  <= 9'd256;
      cfg.out_width   <= 9'd256;
      cfg.row_offset  <= '0;
      cfg.col_offset  <= '0;
      cfg.mode_bits   <= '0;
      cfg.mean_pixel  <= '0;
      cfg.color_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUT_HEIGHT:  cfg.out_height  <= cfg_data[DIM_W-1:0];
        REG_OUT_WIDTH:   cfg.out_width   <= cfg_data[DIM_W-1:0];
        REG_ROW_OFFSET:  cfg.row_offset  <= cfg_data[COORD_W-1:0];
        REG_COL_OFFSET:  cfg.col_offset  <= cfg_data[COORD_W-1:0];
        REG_MODE_BITS:   cfg.mode_bits   <= cfg_data[2:0];
        REG_MEAN_PIXEL:  cfg.mean_pixel  <= cfg_data[NCHAN*PIX_W-1:0];
        REG_COLOR_SHIFT: cfg.color_shift <= cfg_data[NCHAN*SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: the result register frees on the last channel taken,
  // a pixel outside the window leaves the input register without it
  assign held_drain = held_valid && !res_stall && (sel == 2'd2);
  assign held_ready = !held_valid || held_drain;
  assign in_adv     = in_valid && (held_ready || !calc_hit);
  assign pix_stall  = in_valid && !in_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!pix_stall) begin
      in_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && !pix_stall) begin
      in_pix.src_row <= src_row;
      in_pix.src_col <= src_col;
      in_pix.chan    <= {chan2, chan1, chan0};
    end
  end

  cmmp_calc #(
    .MAX_DIM    (MAX_DIM),
    .PAD_PIXELS (PAD_PIXELS)
  ) u_calc (
    .cfg (cfg),
    .pix (in_pix),
    .hit (calc_hit),
    .res (calc_res)
  );

  // Result register and channel select
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      sel        <= '0;
    end else begin
      if (held_ready) begin
        held_valid <= in_valid && calc_hit;
      end
      if (held_valid && !res_stall) begin
        sel <= (sel == 2'd2) ? 2'd0 : sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (held_ready && in_valid && calc_hit) begin
      held_res <= calc_res;
    end
  end

  // Result port
  assign res_valid     = held_valid;
  assign dest_index    = held_res.idx[sel];
  assign out_value     = held_res.val[sel];
  assign last_of_pixel = (sel == 2'd2);

endmodule
